>>> hw/rtl/ftsf_pkg.sv
// Package for the four-tank state feedback step block.
// Shared constants, enum and struct types and the coefficient term table.
// No dependencies.
package ftsf_pkg;

  localparam int NumTanks  = 4;
  localparam int NumFlows  = 2;
  localparam int CoefW     = 16;   // Q4.12 coefficient
  localparam int FracW     = 12;
  localparam int DigW      = 4;    // multiplier digit
  localparam int NumDig    = CoefW / DigW;
  localparam int DigCntW   = $clog2(NumDig);
  localparam int NumTerms  = 14;
  localparam int TermW     = $clog2(NumTerms);
  localparam int NumRows   = 6;
  localparam int RowW      = $clog2(NumRows);
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 18;
  localparam int MaxLevelW = 17;
  localparam int StatusW   = 2;

  localparam logic [RowW-1:0] LastLevelRow = RowW'(3);
  localparam logic [RowW-1:0] FlowRowA     = RowW'(4);

  // reset values
  localparam int LevelRst [NumTanks] = '{2568, 2605, 2671, 2593};
  localparam int FlowRst  [NumFlows] = '{-19452, -19911};
  localparam int MaxLevelRst = 5325;
  localparam int MaxFlowRst  = 10240;
  localparam int OffsetRst [NumTanks] = '{2662, 2703, 2662, 2703};

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_LEVEL    = 3'd0,
    REG_MAX_FLOW     = 3'd1,
    REG_OFFSET_ONE   = 3'd2,
    REG_OFFSET_TWO   = 3'd3,
    REG_OFFSET_THREE = 3'd4,
    REG_OFFSET_FOUR  = 3'd5
  } cfg_reg_e;

  typedef enum logic [StatusW-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_LEVEL = 2'd1,
    FAULT_FLOW  = 2'd2
  } fault_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_ROUND,
    S_CHECK,
    S_PUSH
  } state_e;

  typedef enum logic [2:0] {
    SRC_L0,
    SRC_L1,
    SRC_L2,
    SRC_L3,
    SRC_F0,
    SRC_F1
  } src_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coef;
    src_e                    src;
    logic                    first;  // clears the accumulator
    logic                    last;   // closes a row
  } term_t;

  typedef struct packed {
    logic ld;
    logic clr;
  } mac_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_sts_t;

  // Nonzero coefficients of A|B rows, then the two K rows.
  function automatic term_t term_f(input logic [TermW-1:0] idx);
    term_t t;
    unique case (idx)
      4'd0:    t = '{16'sd3858,   SRC_L0, 1'b1, 1'b0};
      4'd1:    t = '{16'sd165,    SRC_L2, 1'b0, 1'b0};
      4'd2:    t = '{16'sd55,     SRC_F0, 1'b0, 1'b0};
      4'd3:    t = '{16'sd2,      SRC_F1, 1'b0, 1'b1};
      4'd4:    t = '{16'sd3824,   SRC_L1, 1'b1, 1'b0};
      4'd5:    t = '{16'sd155,    SRC_L3, 1'b0, 1'b0};
      4'd6:    t = '{16'sd2,      SRC_F0, 1'b0, 1'b0};
      4'd7:    t = '{16'sd73,     SRC_F1, 1'b0, 1'b1};
      4'd8:    t = '{16'sd3926,   SRC_L2, 1'b1, 1'b0};
      4'd9:    t = '{16'sd111,    SRC_F1, 1'b0, 1'b1};
      4'd10:   t = '{16'sd3935,   SRC_L3, 1'b1, 1'b0};
      4'd11:   t = '{16'sd130,    SRC_F0, 1'b0, 1'b1};
      4'd12:   t = '{-16'sd30727, SRC_L3, 1'b1, 1'b1};
      4'd13:   t = '{-16'sd30537, SRC_L2, 1'b1, 1'b1};
      default: t = '{16'sd0,      SRC_L0, 1'b1, 1'b1};
    endcase
    return t;
  endfunction

endpackage

>>> hw/rtl/ftsf_mac.sv
// Digit-serial multiply-accumulate: 4-bit coefficient digit per cycle.
// Output is the Q.24 accumulator rounded to Q.12 and saturated.
// Depends on ftsf_pkg.
module ftsf_mac import ftsf_pkg::*; #(
  parameter int DW = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mac_cmd_t             cmd_i,
  input  logic signed [DW-1:0] val_i,
  input  logic signed [CoefW-1:0] coef_i,
  output mac_sts_t             sts_o,
  output logic signed [DW-1:0] res_o
);

  localparam int AW = DW + 17;

  logic signed [AW-1:0]    mcand_q, acc_q, acc_d, rsum, rshf;
  logic signed [CoefW-1:0] coef_q;
  logic [DigCntW-1:0]      dig_q;
  logic                    busy_q, done_q, last_dig;
  logic signed [DigW:0]    digit;
  logic signed [AW+DigW:0] prod;

  localparam logic signed [AW-1:0] MaxV = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [AW-1:0] MinV = ~MaxV;
  localparam logic signed [AW-1:0] Half = AW'(1) <<< (FracW - 1);

  assign last_dig = (dig_q == DigCntW'(NumDig - 1));
  // low digits unsigned, top digit carries the sign
  assign digit = last_dig ? {coef_q[DigW-1], coef_q[DigW-1:0]}
                          : {1'b0, coef_q[DigW-1:0]};
  assign prod  = mcand_q * digit;
  assign acc_d = acc_q + prod[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      dig_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.ld) begin
        busy_q <= 1'b1;
        dig_q  <= '0;
      end else if (busy_q) begin
        dig_q <= dig_q + DigCntW'(1);
        if (last_dig) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      mcand_q <= {{(AW-DW){val_i[DW-1]}}, val_i};
      coef_q  <= coef_i;
      if (cmd_i.clr) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      acc_q   <= acc_d;
      mcand_q <= mcand_q <<< DigW;
      coef_q  <= coef_q >>> DigW;
    end
  end

  // round half up, then clamp
  assign rsum = acc_q + Half;
  assign rshf = rsum >>> FracW;
  always_comb begin
    if (rshf > MaxV) begin
      res_o = MaxV[DW-1:0];
    end else if (rshf < MinV) begin
      res_o = MinV[DW-1:0];
    end else begin
      res_o = rshf[DW-1:0];
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

`ifndef SYNTHESIS
  a_no_ld_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld |-> !busy_q) else $error("mac loaded while busy");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && ($past(dig_q) == DigCntW'(NumDig - 1)))
    else $error("mac done without last digit");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("mac done while busy");
`endif

endmodule

>>> hw/rtl/ftsf_out.sv
// Output register stage: absolute levels (deviation plus offset, saturated)
// and the result hold register with valid/stall. Depends on ftsf_pkg.
module ftsf_out import ftsf_pkg::*; #(
  parameter int DW = 18
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  output logic                         free_o,
  input  logic signed [DW-1:0]         lvl_i [NumTanks],
  input  logic signed [CfgDataW-1:0]   ofs_i [NumTanks],
  input  logic signed [DW-1:0]         flow_i [NumFlows],
  input  logic [StatusW-1:0]           status_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic signed [DW-1:0]         lvl_o [NumTanks],
  output logic signed [DW-1:0]         abs_o [NumTanks],
  output logic signed [DW-1:0]         flow_o [NumFlows],
  output logic [StatusW-1:0]           status_o
);

  localparam int SW = ((DW > CfgDataW) ? DW : CfgDataW) + 1;
  localparam logic signed [SW-1:0] MaxV = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] MinV = ~MaxV;

  logic                 valid_q;
  logic signed [SW-1:0] sum [NumTanks];
  logic signed [DW-1:0] abs_d [NumTanks];

  always_comb begin
    for (int i = 0; i < NumTanks; i++) begin
      sum[i] = {{(SW-DW){lvl_i[i][DW-1]}}, lvl_i[i]}
             + {{(SW-CfgDataW){ofs_i[i][CfgDataW-1]}}, ofs_i[i]};
      if (sum[i] > MaxV) begin
        abs_d[i] = MaxV[DW-1:0];
      end else if (sum[i] < MinV) begin
        abs_d[i] = MinV[DW-1:0];
      end else begin
        abs_d[i] = sum[i][DW-1:0];
      end
    end
  end

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lvl_o    <= lvl_i;
      abs_o    <= abs_d;
      flow_o   <= flow_i;
      status_o <= status_i;
    end
  end

  assign out_valid_o = valid_q;

endmodule

>>> hw/rtl/four_tank_state_feedback_step_top.sv
// Four-tank plant model with state feedback, top level.
// Holds the sequencer, plant state, config registers; uses ftsf_mac and
// ftsf_out, and ftsf_pkg.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o, payload tick_i): each item is
//   one sample. tick_i = 1 advances the model once unless a fault is
//   latched; tick_i = 0 just reports the current state.
// - Output channel (out_valid_o / out_stall_i): exactly one result item per
//   input item, showing the state after that item's update.
// - Config port (cfg_we_i, cfg_idx_i, cfg_wdata_i): writes max_level,
//   max_flow and the four tank offsets. Index 6 and 7 are ignored. Write
//   only while no item is in flight.
// - Timing: one item at a time. An advancing tick runs 14 coefficient
//   terms through the digit-serial MAC (load, 4 digits, done), then a
//   round and a limit check per row over 6 rows, plus accept and
//   hand-off. A fault stops the sequence early. A non-advancing item goes
//   from S_IDLE straight to S_PUSH and on to the output stage.
// - The output register decouples the sides: the next item is accepted and
//   worked on while a result waits; the sequencer only waits at hand-off
//   if the previous result is still stalled.
// - Reset: levels -> 2568/2605/2671/2593, flows -> -19452/-19911, status 0,
//   config registers to their defaults; output channel empty.
module four_tank_state_feedback_step_top import ftsf_pkg::*; #(
  parameter int DATA_WIDTH = 18
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         tick_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] level_dev_one_o,
  output logic signed [DATA_WIDTH-1:0] level_dev_two_o,
  output logic signed [DATA_WIDTH-1:0] level_dev_three_o,
  output logic signed [DATA_WIDTH-1:0] level_dev_four_o,
  output logic signed [DATA_WIDTH-1:0] abs_level_one_o,
  output logic signed [DATA_WIDTH-1:0] abs_level_two_o,
  output logic signed [DATA_WIDTH-1:0] abs_level_three_o,
  output logic signed [DATA_WIDTH-1:0] abs_level_four_o,
  output logic signed [DATA_WIDTH-1:0] flow_a_o,
  output logic signed [DATA_WIDTH-1:0] flow_b_o,
  output logic [StatusW-1:0]           status_o,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxW-1:0]           cfg_idx_i,
  input  logic [CfgDataW-1:0]          cfg_wdata_i
);

  localparam int DW = DATA_WIDTH;
  // compare width: holds the level, both limits and their signs
  localparam int CW = ((DW > CfgDataW) ? DW : CfgDataW) + 1;

  state_e state_q, state_d;
  fault_e fault_q, fault_d;
  logic [TermW-1:0] term_q, term_d;
  logic [RowW-1:0]  row_q, row_d;
  term_t            term_s;

  // plant state and scratch
  logic signed [DW-1:0] level_q [NumTanks];
  logic signed [DW-1:0] flow_q  [NumFlows];
  logic signed [DW-1:0] nl_q    [NumTanks-1];
  logic signed [DW-1:0] nf0_q, rnd_q;

  // config
  logic [MaxLevelW-1:0]       max_level_q;
  logic signed [CfgDataW-1:0] max_flow_q;
  logic signed [CfgDataW-1:0] offset_q [NumTanks];

  logic nl_we, lvl_we, nf0_we, flow_we, rnd_we, out_load, out_free;
  logic over_level, over_flow;
  logic signed [CW-1:0] rnd_ext, lim_level, lim_flow;

  mac_cmd_t             mac_cmd;
  mac_sts_t             mac_sts;
  logic signed [DW-1:0] mac_val, mac_res;

  assign term_s = term_f(term_q);

  // MAC operand select
  always_comb begin
    unique case (term_s.src)
      SRC_L0:  mac_val = level_q[0];
      SRC_L1:  mac_val = level_q[1];
      SRC_L2:  mac_val = level_q[2];
      SRC_L3:  mac_val = level_q[3];
      SRC_F0:  mac_val = flow_q[0];
      SRC_F1:  mac_val = flow_q[1];
      default: mac_val = level_q[0];
    endcase
  end

  ftsf_mac #(.DW(DW)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .val_i  (mac_val),
    .coef_i (term_s.coef),
    .sts_o  (mac_sts),
    .res_o  (mac_res)
  );

  // limit compares on the rounded, saturated row value
  assign rnd_ext    = {{(CW-DW){rnd_q[DW-1]}}, rnd_q};
  assign lim_level  = {{(CW-MaxLevelW){1'b0}}, max_level_q};
  assign lim_flow   = {{(CW-CfgDataW){max_flow_q[CfgDataW-1]}}, max_flow_q};
  assign over_level = rnd_ext > lim_level;
  assign over_flow  = rnd_ext > lim_flow;

  assign in_stall_o = (state_q != S_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    fault_d     = fault_q;
    term_d      = term_q;
    row_d       = row_q;
    mac_cmd.ld  = 1'b0;
    mac_cmd.clr = 1'b0;
    nl_we       = 1'b0;
    lvl_we      = 1'b0;
    nf0_we      = 1'b0;
    flow_we     = 1'b0;
    rnd_we      = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          term_d = '0;
          row_d  = '0;
          if (tick_i && (fault_q == FAULT_NONE)) begin
            state_d = S_LOAD;
          end else begin
            state_d = S_PUSH;
          end
        end
      end
      S_LOAD: begin
        mac_cmd.ld  = 1'b1;
        mac_cmd.clr = term_s.first;
        state_d     = S_MUL;
      end
      S_MUL: begin
        if (mac_sts.done) begin
          if (term_s.last) begin
            state_d = S_ROUND;
          end else begin
            term_d  = term_q + TermW'(1);
            state_d = S_LOAD;
          end
        end
      end
      S_ROUND: begin
        rnd_we  = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = S_LOAD;
        term_d  = term_q + TermW'(1);
        row_d   = row_q + RowW'(1);
        if (row_q <= LastLevelRow) begin
          if (over_level) begin
            fault_d = FAULT_LEVEL;
            state_d = S_PUSH;
          end else begin
            nl_we  = 1'b1;
            lvl_we = (row_q == LastLevelRow);
          end
        end else if (over_flow) begin
          fault_d = FAULT_FLOW;
          state_d = S_PUSH;
        end else if (row_q == FlowRowA) begin
          nf0_we = 1'b1;
        end else begin
          flow_we = 1'b1;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fault_q <= FAULT_NONE;
      term_q  <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      fault_q <= fault_d;
      term_q  <= term_d;
      row_q   <= row_d;
    end
  end

  // plant state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTanks; i++) begin
        level_q[i] <= DW'(LevelRst[i]);
      end
      for (int i = 0; i < NumFlows; i++) begin
        flow_q[i] <= DW'(FlowRst[i]);
      end
    end else begin
      if (lvl_we) begin
        for (int i = 0; i < NumTanks - 1; i++) begin
          level_q[i] <= nl_q[i];
        end
        level_q[NumTanks-1] <= rnd_q;
      end
      if (flow_we) begin
        flow_q[0] <= nf0_q;
        flow_q[1] <= rnd_q;
      end
    end
  end

  // scratch registers
  always_ff @(posedge clk_i) begin
    if (rnd_we) begin
      rnd_q <= mac_res;
    end
    if (nf0_we) begin
      nf0_q <= rnd_q;
    end
    for (int i = 0; i < NumTanks - 1; i++) begin
      if (nl_we && (row_q == RowW'(i))) begin
        nl_q[i] <= rnd_q;
      end
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= MaxLevelW'(MaxLevelRst);
      max_flow_q  <= CfgDataW'(MaxFlowRst);
      for (int i = 0; i < NumTanks; i++) begin
        offset_q[i] <= CfgDataW'(OffsetRst[i]);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MAX_LEVEL:    max_level_q <= cfg_wdata_i[MaxLevelW-1:0];
        REG_MAX_FLOW:     max_flow_q  <= cfg_wdata_i;
        REG_OFFSET_ONE:   offset_q[0] <= cfg_wdata_i;
        REG_OFFSET_TWO:   offset_q[1] <= cfg_wdata_i;
        REG_OFFSET_THREE: offset_q[2] <= cfg_wdata_i;
        REG_OFFSET_FOUR:  offset_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic signed [DW-1:0] lvl_out  [NumTanks];
  logic signed [DW-1:0] abs_out  [NumTanks];
  logic signed [DW-1:0] flow_out [NumFlows];

  ftsf_out #(.DW(DW)) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .free_o      (out_free),
    .lvl_i       (level_q),
    .ofs_i       (offset_q),
    .flow_i      (flow_q),
    .status_i    (fault_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .lvl_o       (lvl_out),
    .abs_o       (abs_out),
    .flow_o      (flow_out),
    .status_o    (status_o)
  );

  assign level_dev_one_o   = lvl_out[0];
  assign level_dev_two_o   = lvl_out[1];
  assign level_dev_three_o = lvl_out[2];
  assign level_dev_four_o  = lvl_out[3];
  assign abs_level_one_o   = abs_out[0];
  assign abs_level_two_o   = abs_out[1];
  assign abs_level_three_o = abs_out[2];
  assign abs_level_four_o  = abs_out[3];
  assign flow_a_o          = flow_out[0];
  assign flow_b_o          = flow_out[1];

`ifndef SYNTHESIS
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_q != FAULT_NONE) |=> (fault_q == $past(fault_q)))
    else $error("latched fault changed");
  a_commit_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_we |=> (fault_q == FAULT_NONE))
    else $error("levels committed with a fault");
  a_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_sts.done |-> (state_q == S_MUL))
    else $error("mac result outside multiply state");
`endif

endmodule
